@@ rtl/core/smce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smce_pkg
// Shared types, constants and digit helpers for the servo move encoder.
// ----------------------------------------------------------------------------
package smce_pkg;

  localparam int MAX_MOVES_DEF = 8;

  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PULSE = 2'd0,
    REG_MAX_PULSE = 2'd1,
    REG_MAX_TIME  = 2'd2,
    REG_GROUP     = 2'd3
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] MIN_PULSE_RST = 14'd500;
  localparam logic [CFG_W-1:0] MAX_PULSE_RST = 14'd2500;
  localparam logic [CFG_W-1:0] MAX_TIME_RST  = 14'd9999;
  localparam logic             GROUP_RST     = 1'b1;

  localparam logic [15:0] DIGIT_LIMIT = 16'd9999;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef logic [7:0]  id_t;
  typedef logic [15:0] field16_t;
  typedef logic [13:0] value_t;
  typedef logic [7:0]  byte_t;

  // byte slots of the longest word sequence
  typedef enum logic [4:0] {
    SL_ABORT, SL_LBRACE, SL_G, SL_Z0, SL_Z1, SL_Z2, SL_Z3,
    SL_HASH, SL_ID2, SL_ID1, SL_ID0,
    SL_P, SL_P3, SL_P2, SL_P1, SL_P0,
    SL_T, SL_T3, SL_T2, SL_T1, SL_T0,
    SL_BANG, SL_RBRACE
  } slot_t;

  typedef enum logic [1:0] {
    PL_1000, PL_100, PL_10, PL_1
  } place_t;

  // one decoded move, handed from the frame control to the byte sequencer
  typedef struct packed {
    logic   bad;
    logic   pre;
    logic   hdr;
    logic   trl;
    logic   grp;
    id_t    id;
    value_t pulse;
    value_t tms;
  } plan_t;

  // leading decimal digit of w at the given place (w below ten times place)
  function automatic logic [3:0] digit_q(input value_t w, input place_t pl);
    logic [27:0] p;
    logic [3:0]  q;
    p = '0;
    q = '0;
    case (pl)
      PL_1000: begin
        p = 28'(w) * 28'd8389;
        q = p[26:23];
      end
      PL_100: begin
        p = 28'(w) * 28'd41;
        q = p[15:12];
      end
      PL_10: begin
        p = 28'(w) * 28'd103;
        q = p[13:10];
      end
      default: begin
        q = w[3:0];
      end
    endcase
    return q;
  endfunction

  function automatic value_t place_val(input place_t pl);
    value_t v;
    case (pl)
      PL_1000: v = 14'd1000;
      PL_100:  v = 14'd100;
      PL_10:   v = 14'd10;
      default: v = 14'd1;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/smce_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smce_in_if / smce_out_if
// Valid/ready channels for moves in and frame bytes out.
// ----------------------------------------------------------------------------
interface smce_in_if;
  logic               valid;
  logic               ready;
  smce_pkg::id_t      servo_id;
  smce_pkg::field16_t pulse_width;
  smce_pkg::field16_t time_ms;
  logic               last_move;

  modport source (output valid, servo_id, pulse_width, time_ms, last_move, input ready);
  modport sink   (input valid, servo_id, pulse_width, time_ms, last_move, output ready);
endinterface

interface smce_out_if;
  logic            valid;
  logic            ready;
  smce_pkg::byte_t out_byte;
  logic            run_last;
  logic            frame_end;
  logic            abort;

  modport source (output valid, out_byte, run_last, frame_end, abort, input ready);
  modport sink   (input valid, out_byte, run_last, frame_end, abort, output ready);
endinterface

@@ rtl/core/smce_frame_ctl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smce_frame_ctl
// Config registers, move checks and group frame state; decodes each move.
// ----------------------------------------------------------------------------
module smce_frame_ctl #(
  parameter int MAX_MOVES = smce_pkg::MAX_MOVES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [smce_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [smce_pkg::CFG_W-1:0]         cfg_wdata,
  input  smce_pkg::id_t                      servo_id,
  input  smce_pkg::field16_t                 pulse_width,
  input  smce_pkg::field16_t                 time_ms,
  input  logic                               last_move,
  input  logic                               in_fire,
  output smce_pkg::plan_t                    plan
);
  import smce_pkg::*;

  localparam int CNT_W = $clog2(MAX_MOVES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MOVES);

  value_t           min_pulse_r, max_pulse_r, max_time_r;
  logic             group_r;
  logic             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0] moves_r, moves_nxt;
  logic             bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r <= MIN_PULSE_RST;
      max_pulse_r <= MAX_PULSE_RST;
      max_time_r  <= MAX_TIME_RST;
      group_r     <= GROUP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_MIN_PULSE: min_pulse_r <= cfg_wdata;
        REG_MAX_PULSE: max_pulse_r <= cfg_wdata;
        REG_MAX_TIME:  max_time_r  <= cfg_wdata;
        REG_GROUP:     group_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bad = (pulse_width < 16'(min_pulse_r)) || (pulse_width > 16'(max_pulse_r)) ||
          (pulse_width > DIGIT_LIMIT) || (time_ms > 16'(max_time_r)) ||
          (time_ms > DIGIT_LIMIT) || (group_r && in_frame_r && (moves_r >= CNT_MAX));

    plan.bad   = bad;
    plan.pre   = !bad && !group_r && in_frame_r;
    plan.hdr   = !bad && group_r && !in_frame_r;
    plan.trl   = !bad && group_r && last_move;
    plan.grp   = group_r;
    plan.id    = servo_id;
    plan.pulse = pulse_width[13:0];
    plan.tms   = time_ms[13:0];

    in_frame_nxt = 1'b0;
    moves_nxt    = '0;
    if (!bad && group_r && !last_move) begin
      in_frame_nxt = 1'b1;
      moves_nxt    = in_frame_r ? moves_r + CNT_W'(1) : CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      moves_r    <= '0;
    end else if (in_fire) begin
      in_frame_r <= in_frame_nxt;
      moves_r    <= moves_nxt;
    end
  end

endmodule

@@ rtl/core/smce_byte_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smce_byte_seq
// Holds one decoded move and walks its byte slots into the output register.
// ----------------------------------------------------------------------------
module smce_byte_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  smce_pkg::plan_t  plan_in,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output smce_pkg::byte_t  out_byte,
  output logic             out_run_last,
  output logic             out_frame_end,
  output logic             out_abort
);
  import smce_pkg::*;

  plan_t  plan_r;
  logic   plan_valid_r;
  slot_t  pos_r, pos_nxt, start_pos;
  value_t w_r, w_nxt;

  logic   out_valid_r;
  byte_t  byte_r;
  logic   run_last_r, frame_end_r, abort_r;

  byte_t  cur_byte;
  logic   cur_fend, cur_abort, dig_en, last_slot, adv, fire;
  place_t place;
  logic [3:0] q;

  assign adv      = plan_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !plan_valid_r || (adv && last_slot);
  assign fire     = in_valid && in_ready;

  always_comb begin
    cur_byte  = CH_NUL;
    cur_fend  = 1'b0;
    cur_abort = 1'b0;
    dig_en    = 1'b0;
    place     = PL_1;
    case (pos_r)
      SL_ABORT:  cur_abort = 1'b1;
      SL_LBRACE: cur_byte = CH_LBRACE;
      SL_G:      cur_byte = CH_G;
      SL_Z0, SL_Z1, SL_Z2, SL_Z3: cur_byte = CH_ZERO;
      SL_HASH:   cur_byte = CH_HASH;
      SL_P:      cur_byte = CH_P;
      SL_T:      cur_byte = CH_T;
      SL_P3, SL_T3: begin
        dig_en = 1'b1;
        place  = PL_1000;
      end
      SL_ID2, SL_P2, SL_T2: begin
        dig_en = 1'b1;
        place  = PL_100;
      end
      SL_ID1, SL_P1, SL_T1: begin
        dig_en = 1'b1;
        place  = PL_10;
      end
      SL_ID0, SL_P0, SL_T0: begin
        dig_en = 1'b1;
        place  = PL_1;
      end
      SL_BANG: begin
        cur_byte = CH_BANG;
        cur_fend = !plan_r.grp;
      end
      SL_RBRACE: begin
        cur_byte = CH_RBRACE;
        cur_fend = 1'b1;
      end
      default: ;
    endcase
    q = digit_q(w_r, place);
    if (dig_en) begin
      cur_byte = CH_ZERO + {4'b0000, q};
    end
  end

  always_comb begin
    last_slot = plan_r.bad ? (pos_r == SL_ABORT)
                           : ((pos_r == SL_BANG && !plan_r.trl) || pos_r == SL_RBRACE);
    case (pos_r)
      SL_ABORT: pos_nxt = plan_r.hdr ? SL_LBRACE : SL_HASH;
      default:  pos_nxt = slot_t'(pos_r + 5'd1);
    endcase
    case (pos_r)
      SL_HASH: w_nxt = {6'b000000, plan_r.id};
      SL_P:    w_nxt = plan_r.pulse;
      SL_T:    w_nxt = plan_r.tms;
      default: w_nxt = dig_en ? w_r - 14'(14'(q) * place_val(place)) : w_r;
    endcase
    if (plan_in.bad || plan_in.pre) begin
      start_pos = SL_ABORT;
    end else if (plan_in.hdr) begin
      start_pos = SL_LBRACE;
    end else begin
      start_pos = SL_HASH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        plan_valid_r <= 1'b1;
      end else if (adv && last_slot) begin
        plan_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      plan_r <= plan_in;
      pos_r  <= start_pos;
    end else if (adv) begin
      pos_r  <= pos_nxt;
    end
    if (adv) begin
      w_r         <= w_nxt;
      byte_r      <= cur_byte;
      run_last_r  <= last_slot;
      frame_end_r <= cur_fend;
      abort_r     <= cur_abort;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = byte_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;
  assign out_abort     = abort_r;

endmodule

@@ rtl/core/servo_move_command_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_move_command_encoder
// Encodes servo moves as ASCII command words, grouped or single frames.
// ----------------------------------------------------------------------------
// A move is registered on acceptance, and its first word then goes through the
//   output register to out_word. Throughput: one word per cycle while out_word is
//   ready; a move's words are set by the byte sequencer that emits one word per slot.
// The next move is taken in the cycle its predecessor's last word is issued.
// Reset (rst_n low, synchronous): no frame open, registers at defaults.
// ----------------------------------------------------------------------------
module servo_move_command_encoder #(
  parameter int MAX_MOVES = smce_pkg::MAX_MOVES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [smce_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [smce_pkg::CFG_W-1:0]     cfg_wdata,
  smce_in_if.sink                        in_word,
  smce_out_if.source                     out_word
);
  import smce_pkg::*;

  plan_t plan;
  logic  in_fire;

  assign in_fire = in_word.valid && in_word.ready;

  smce_frame_ctl #(
    .MAX_MOVES (MAX_MOVES)
  ) u_frame_ctl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .servo_id    (in_word.servo_id),
    .pulse_width (in_word.pulse_width),
    .time_ms     (in_word.time_ms),
    .last_move   (in_word.last_move),
    .in_fire     (in_fire),
    .plan        (plan)
  );

  smce_byte_seq u_byte_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .plan_in       (plan),
    .in_valid      (in_word.valid),
    .in_ready      (in_word.ready),
    .out_valid     (out_word.valid),
    .out_ready     (out_word.ready),
    .out_byte      (out_word.out_byte),
    .out_run_last  (out_word.run_last),
    .out_frame_end (out_word.frame_end),
    .out_abort     (out_word.abort)
  );

endmodule

@@ rtl/core/smce_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smce_port_props
// Port-level checks on the encoder's output words.
// ----------------------------------------------------------------------------
module smce_port_props (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input smce_pkg::byte_t out_byte,
  input logic            out_run_last,
  input logic            out_frame_end,
  input logic            out_abort
);
  import smce_pkg::*;

  // an abort word carries nothing
  a_abort_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_abort |-> out_byte == CH_NUL && !out_frame_end)
    else $error("abort word carries data");

  // a frame closes only on the final word of a move
  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_run_last &&
      (out_byte == CH_BANG || out_byte == CH_RBRACE))
    else $error("frame end on wrong word");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_run_last) && $stable(out_abort))
    else $error("stalled word changed");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("word valid after reset");

endmodule

bind servo_move_command_encoder smce_port_props u_smce_port_props (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_word.valid),
  .out_ready     (out_word.ready),
  .out_byte      (out_word.out_byte),
  .out_run_last  (out_word.run_last),
  .out_frame_end (out_word.frame_end),
  .out_abort     (out_word.abort)
);
